[rtl/vsgm_pkg.sv]
package vsgm_pkg;

  localparam int unsigned HISTORY_DEPTH = 64;
  localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned FOLD_W = FILL_W + 5;
  localparam int unsigned STEP_W = 7;
  localparam int unsigned DIV_W = (FILL_W > STEP_W) ? FILL_W : STEP_W;
  localparam int unsigned NUM_W = 64;
  localparam int unsigned DIV_BITS = 4;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W / DIV_BITS);

  localparam logic [63:0] MIX_K1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_K2 = 64'h94d049bb133111eb;
  localparam logic [63:0] SEED_RESET = 64'h0000_0000_474c_4943;
  localparam logic [16:0] ONE_FRAC = 17'h10000;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;

  localparam logic [1:0] REG_EFFECT = 2'd0;
  localparam logic [1:0] REG_AMOUNT = 2'd1;
  localparam logic [1:0] REG_SEED = 2'd2;

  localparam logic [3:0] EFF_NONE = 4'd0;
  localparam logic [3:0] EFF_VORTEX = 4'd1;
  localparam logic [3:0] EFF_MIRROR = 4'd2;
  localparam logic [3:0] EFF_QUANT = 4'd3;
  localparam logic [3:0] EFF_FREEZE = 4'd4;
  localparam logic [3:0] EFF_FLIP = 4'd5;
  localparam logic [3:0] EFF_BAND = 4'd6;
  localparam logic [3:0] EFF_TRANS = 4'd7;
  localparam logic [3:0] EFF_FOLD = 4'd8;

  typedef struct packed {
    logic [3:0]  effect_mode;
    logic [16:0] amount_frac;
    logic [63:0] hash_seed;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_HASH_KEY,
    ST_HASH_SEL,
    ST_HASH_TR,
    ST_DIV_A,
    ST_DIV_B,
    ST_DIV_H,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    HS_KEY,
    HS_MIX,
    HS_TRANS
  } hash_src_e;

  typedef enum logic [1:0] {
    DS_QA,
    DS_QB,
    DS_FOLD,
    DS_TRANS
  } div_src_e;

  typedef struct packed {
    logic      load_in;
    logic      ord_adv;
    logic      hash_start;
    hash_src_e hash_src;
    logic      div_start;
    div_src_e  div_src;
    logic      rem_cap_a;
    logic      rem_cap_b;
    logic      mem_rd;
    logic      sel_load;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic is_coef;
    logic sel_now;
    logic mode_quant;
    logic mode_trans;
    logic mode_fold;
    logic fill_zero;
    logic hash_done;
    logic div_done;
  } dp_sts_t;

endpackage

[rtl/vsgm_if.sv]
interface vsgm_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic [1:0]         lane_id;
  logic [9:0]         coeff_index;
  logic signed [15:0] value_a;
  logic signed [15:0] value_b;

  modport source (output valid, req_type, pos_x, pos_y, lane_id, coeff_index, value_a,
                  value_b, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, lane_id, coeff_index, value_a,
                value_b, output ready);
endinterface

interface vsgm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_a;
  logic signed [15:0] result_b;
  logic               was_selected;
  logic [1:0]         fields_changed;

  modport source (output valid, result_a, result_b, was_selected, fields_changed,
                  input ready);
  modport sink (input valid, result_a, result_b, was_selected, fields_changed,
                output ready);
endinterface

[rtl/vsgm_regs.sv]
module vsgm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vsgm_pkg::PADDR_W-1:0]  paddr,
  input  logic [vsgm_pkg::PDATA_W-1:0]  pwdata,
  output logic [vsgm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output vsgm_pkg::cfg_t                cfg_o
);
  import vsgm_pkg::*;

  logic [3:0]  effect_q;
  logic [16:0] amount_q;
  logic [63:0] seed_q;
  logic        wr;
  logic [1:0]  idx;

  assign wr = psel & penable & pwrite;
  assign idx = paddr[PADDR_W-1:3];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_q <= EFF_NONE;
      amount_q <= '0;
      seed_q <= SEED_RESET;
    end else if (wr) begin
      case (idx)
        REG_EFFECT: effect_q <= pwdata[3:0];
        REG_AMOUNT: amount_q <= pwdata[16:0];
        REG_SEED:   seed_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EFFECT: prdata = PDATA_W'(effect_q);
      REG_AMOUNT: prdata = PDATA_W'(amount_q);
      REG_SEED:   prdata = seed_q;
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = '{effect_mode: effect_q, amount_frac: amount_q, hash_seed: seed_q};
endmodule

[rtl/vsgm_hash.sv]
module vsgm_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] din_i,
  output logic        done_o,
  output logic [63:0] dout_o
);
  import vsgm_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [2:0]  cnt_q;
  logic [63:0] v_q;
  logic [63:0] acc_q;
  logic [63:0] k;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  // low 64 bits of v * k from three 32x32 partial products
  assign k = cnt_q[2] ? MIX_K2 : MIX_K1;
  assign op_a = (cnt_q[1:0] == 2'd1) ? v_q[63:32] : v_q[31:0];
  assign op_b = (cnt_q[1:0] == 2'd2) ? k[63:32] : k[31:0];
  assign prod = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd7);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= din_i ^ (din_i >> 30);
    end else if (busy_q) begin
      case (cnt_q[1:0])
        2'd0: acc_q <= prod;
        2'd1: acc_q <= acc_q + {prod[31:0], 32'h0};
        2'd2: acc_q <= acc_q + {prod[31:0], 32'h0};
        2'd3: v_q <= cnt_q[2] ? (acc_q ^ (acc_q >> 31)) : (acc_q ^ (acc_q >> 27));
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign dout_o = v_q;
endmodule

[rtl/vsgm_div.sv]
module vsgm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vsgm_pkg::NUM_W-1:0]   num_i,
  input  logic [vsgm_pkg::DIV_W-1:0]   den_i,
  output logic                         done_o,
  output logic [vsgm_pkg::DIV_W-1:0]   rem_o
);
  import vsgm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     n_q;
  logic [DIV_W-1:0]     d_q;
  logic [DIV_W-1:0]     r_q;
  logic [DIV_W-1:0]     r_c;
  logic [DIV_W:0]       t_c;

  // restoring remainder, several numerator bits per cycle
  always_comb begin
    r_c = r_q;
    t_c = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t_c = {r_c, n_q[NUM_W-1-i]};
      if (t_c >= {1'b0, d_q}) t_c = t_c - {1'b0, d_q};
      r_c = t_c[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(NUM_W / DIV_BITS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(NUM_W / DIV_BITS - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
    end else if (busy_q) begin
      n_q <= n_q << DIV_BITS;
      r_q <= r_c;
    end
  end

  assign done_o = done_q;
  assign rem_o = r_q;
endmodule

[rtl/vsgm_ctrl.sv]
module vsgm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  vsgm_pkg::dp_sts_t sts_i,
  output vsgm_pkg::dp_cmd_t cmd_o
);
  import vsgm_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE:   state_d = sts_i.active ? ST_HASH_KEY : ST_FIN;
      ST_HASH_KEY: if (sts_i.hash_done) state_d = ST_HASH_SEL;
      ST_HASH_SEL: begin
        if (sts_i.hash_done) begin
          if (!sts_i.sel_now) state_d = ST_FIN;
          else if (!sts_i.is_coef) state_d = sts_i.mode_quant ? ST_DIV_A : ST_FIN;
          else if (sts_i.fill_zero) state_d = ST_FIN;
          else if (sts_i.mode_trans) state_d = ST_HASH_TR;
          else if (sts_i.mode_fold) state_d = ST_DIV_H;
          else state_d = ST_FIN;
        end
      end
      ST_HASH_TR:  if (sts_i.hash_done) state_d = ST_DIV_H;
      ST_DIV_A:    if (sts_i.div_done) state_d = ST_DIV_B;
      ST_DIV_B:    if (sts_i.div_done) state_d = ST_FIN;
      ST_DIV_H:    if (sts_i.div_done) state_d = ST_FIN;
      ST_FIN:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_DECIDE: begin
        if (sts_i.active) begin
          cmd_o.ord_adv = 1'b1;
          cmd_o.hash_start = 1'b1;
          cmd_o.hash_src = HS_KEY;
        end
      end
      ST_HASH_KEY: begin
        if (sts_i.hash_done) begin
          cmd_o.hash_start = 1'b1;
          cmd_o.hash_src = HS_MIX;
        end
      end
      ST_HASH_SEL: begin
        if (sts_i.hash_done) begin
          cmd_o.sel_load = 1'b1;
          if (sts_i.sel_now && !sts_i.is_coef && sts_i.mode_quant) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_src = DS_QA;
          end
          if (sts_i.sel_now && sts_i.is_coef && !sts_i.fill_zero) begin
            if (sts_i.mode_trans) begin
              cmd_o.hash_start = 1'b1;
              cmd_o.hash_src = HS_TRANS;
            end else if (sts_i.mode_fold) begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_src = DS_FOLD;
            end
          end
        end
      end
      ST_HASH_TR: begin
        if (sts_i.hash_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src = DS_TRANS;
        end
      end
      ST_DIV_A: begin
        if (sts_i.div_done) begin
          cmd_o.rem_cap_a = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src = DS_QB;
        end
      end
      ST_DIV_B: cmd_o.rem_cap_b = sts_i.div_done;
      ST_DIV_H: cmd_o.mem_rd = sts_i.div_done;
      ST_FIN:   cmd_o.finish = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.finish || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

[rtl/vsgm_dp.sv]
module vsgm_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vsgm_pkg::cfg_t     cfg_i,
  input  vsgm_pkg::dp_cmd_t  cmd_i,
  output vsgm_pkg::dp_sts_t  sts_o,
  input  logic               req_type_i,
  input  logic [15:0]        pos_x_i,
  input  logic [15:0]        pos_y_i,
  input  logic [1:0]         lane_id_i,
  input  logic [9:0]         coeff_index_i,
  input  logic signed [15:0] value_a_i,
  input  logic signed [15:0] value_b_i,
  output logic signed [15:0] result_a_o,
  output logic signed [15:0] result_b_o,
  output logic               was_selected_o,
  output logic [1:0]         fields_changed_o
);
  import vsgm_pkg::*;

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic signed [15:0] clip_mv(input logic signed [20:0] v);
    if (v < -21'sd8192) return -16'sd8192;
    else if (v > 21'sd8191) return 16'sd8191;
    else return v[15:0];
  endfunction

  function automatic logic signed [15:0] clip16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sd32767;
    else if (v < -18'sd32768) return -16'sd32768;
    else return v[15:0];
  endfunction

  // item fields
  logic               type_q;
  logic [15:0]        px_q;
  logic [15:0]        py_q;
  logic [1:0]         lane_q;
  logic [9:0]         cidx_q;
  logic signed [15:0] va_q;
  logic signed [15:0] vb_q;

  // block state
  logic [63:0]        ord_q;
  logic [63:0]        cur_ord_q;
  logic signed [15:0] prev_x_q;
  logic signed [15:0] prev_y_q;
  logic [HIST_AW-1:0] cursor_q;
  logic [FILL_W-1:0]  fill_q;
  logic               sel_q;
  logic [15:0]        hist_mem [HISTORY_DEPTH];
  logic signed [15:0] hist_rd_q;
  logic [STEP_W-1:0]  rem_a_q;
  logic [STEP_W-1:0]  rem_b_q;

  logic signed [15:0] res_a_q;
  logic signed [15:0] res_b_q;
  logic               res_sel_q;
  logic [1:0]         res_chg_q;

  logic [16:0] f_eff;
  logic [3:0]  mode;
  logic        mvd_on;
  logic        coef_on;
  logic        sel_now;
  logic [16:0] x_k;
  logic [2:0]  lane_k;
  logic [63:0] key_in;
  logic [63:0] hash_din;
  logic        hash_done;
  logic [63:0] hash_dout;
  logic [NUM_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic        div_done;
  logic [DIV_W-1:0] div_rem;
  logic [FOLD_W-1:0] fold_t;

  logic [21:0] p3;
  logic [22:0] p60;
  logic [20:0] p10;
  logic [19:0] pc;
  logic [2:0]  gain;
  logic [STEP_W-1:0] step_q;
  logic [3:0]  vort_s;
  logic [3:0]  cap;

  logic [16:0] mag_a;
  logic [16:0] mag_b;
  logic [16:0] n_a;
  logic [16:0] n_b;
  logic [16:0] r_a;
  logic [16:0] r_b;
  logic signed [20:0] va21;
  logic signed [20:0] vb21;
  logic signed [20:0] gs;
  logic signed [20:0] vs;
  logic signed [20:0] q_a;
  logic signed [20:0] q_b;
  logic [3:0]  band_m;
  logic signed [15:0] band_a;
  logic [16:0] hm;
  logic signed [17:0] hs;
  logic signed [15:0] mvd_ra;
  logic signed [15:0] mvd_rb;
  logic signed [15:0] coef_ra;
  logic signed [15:0] ra;
  logic signed [15:0] rb;
  logic [1:0]  nchg;

  assign f_eff = (cfg_i.amount_frac > ONE_FRAC) ? ONE_FRAC : cfg_i.amount_frac;
  assign mode = cfg_i.effect_mode;
  assign mvd_on = (mode >= EFF_VORTEX) && (mode <= EFF_FREEZE);
  assign coef_on = (mode >= EFF_FLIP) && (mode <= EFF_FOLD);

  // selection key
  assign x_k = type_q ? ({1'b0, px_q} + {7'b0, cidx_q}) : {1'b0, px_q};
  assign lane_k = type_q ? ({1'b0, lane_q} + 3'd4) : {1'b0, lane_q};
  assign key_in = {15'b0, x_k, 32'b0} ^ {40'b0, py_q, 8'b0} ^ {5'b0, lane_k, 56'b0} ^ ord_q;

  always_comb begin
    case (cmd_i.hash_src)
      HS_KEY:   hash_din = key_in;
      HS_MIX:   hash_din = cfg_i.hash_seed ^ hash_dout;
      HS_TRANS: hash_din = cur_ord_q ^ cfg_i.hash_seed;
      default:  hash_din = key_in;
    endcase
  end

  vsgm_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.hash_start),
    .din_i   (hash_din),
    .done_o  (hash_done),
    .dout_o  (hash_dout)
  );

  assign sel_now = (f_eff == '0) ? 1'b0 :
                   f_eff[16] ? 1'b1 : (hash_dout < {f_eff[15:0], 48'h0});

  // strengths from the amount
  assign p3 = 22'(f_eff) * 22'd3 + 22'd32768;
  assign p60 = 23'(f_eff) * 23'd60 + 23'd32768;
  assign p10 = 21'(f_eff) * 21'd10 + 21'd32768;
  assign pc = 20'(ONE_FRAC - f_eff) * 20'd7;
  assign gain = 3'd1 + 3'(p3[21:16]);
  assign step_q = 7'd4 + 7'(p60[22:16]);
  assign vort_s = 4'd2 + 4'(p10[20:16]);
  assign cap = 4'd1 + 4'(pc[19:16]);

  // rounding to a step: n - (n mod step) with n = |v| + step/2
  assign mag_a = abs17(va_q);
  assign mag_b = abs17(vb_q);
  assign n_a = mag_a + 17'(step_q[STEP_W-1:1]);
  assign n_b = mag_b + 17'(step_q[STEP_W-1:1]);
  assign fold_t = FOLD_W'(cursor_q) + (FOLD_W'(fill_q) << 3) + FOLD_W'(fill_q)
                  - FOLD_W'(1) - FOLD_W'(cidx_q[2:0]);

  always_comb begin
    case (cmd_i.div_src)
      DS_QA: begin
        div_num = NUM_W'(n_a);
        div_den = DIV_W'(step_q);
      end
      DS_QB: begin
        div_num = NUM_W'(n_b);
        div_den = DIV_W'(step_q);
      end
      DS_FOLD: begin
        div_num = NUM_W'(fold_t);
        div_den = DIV_W'(fill_q);
      end
      DS_TRANS: begin
        div_num = hash_dout;
        div_den = DIV_W'(fill_q);
      end
      default: begin
        div_num = hash_dout;
        div_den = DIV_W'(fill_q);
      end
    endcase
  end

  vsgm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  // mvd results
  assign va21 = 21'(va_q);
  assign vb21 = 21'(vb_q);
  assign gs = $signed(21'(gain));
  assign vs = $signed(21'(vort_s));
  assign r_a = n_a - 17'(rem_a_q);
  assign r_b = n_b - 17'(rem_b_q);
  assign q_a = va_q[15] ? -$signed(21'(r_a)) : $signed(21'(r_a));
  assign q_b = vb_q[15] ? -$signed(21'(r_b)) : $signed(21'(r_b));

  always_comb begin
    case (mode)
      EFF_MIRROR: begin
        mvd_ra = clip_mv(-(va21 * gs));
        mvd_rb = clip_mv(vb21 * gs);
      end
      EFF_QUANT: begin
        mvd_ra = clip_mv(q_a);
        mvd_rb = clip_mv(q_b);
      end
      EFF_FREEZE: begin
        mvd_ra = prev_x_q;
        mvd_rb = prev_y_q;
      end
      EFF_VORTEX: begin
        mvd_ra = clip_mv(-(vb21 * vs));
        mvd_rb = clip_mv(va21 * vs);
      end
      default: begin
        mvd_ra = va_q;
        mvd_rb = vb_q;
      end
    endcase
  end

  // coefficient results
  assign band_m = (mag_a > 17'(cap)) ? cap : 4'(mag_a);
  assign band_a = va_q[15] ? -$signed(16'(band_m)) : $signed(16'(band_m));
  assign hm = (abs17(hist_rd_q) == '0) ? 17'd1 : abs17(hist_rd_q);
  assign hs = va_q[15] ? -$signed(18'(hm)) : $signed(18'(hm));

  always_comb begin
    case (mode)
      EFF_FLIP:  coef_ra = clip16(-18'(va_q));
      EFF_BAND:  coef_ra = band_a;
      EFF_TRANS: coef_ra = (fill_q == '0) ? va_q : clip16(hs);
      EFF_FOLD:  coef_ra = (fill_q == '0) ? va_q : clip16(hs);
      default:   coef_ra = va_q;
    endcase
  end

  assign ra = sel_q ? (type_q ? coef_ra : mvd_ra) : va_q;
  assign rb = type_q ? 16'sd0 : (sel_q ? mvd_rb : vb_q);
  assign nchg = 2'(ra != va_q) + 2'(!type_q && (rb != vb_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_q <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      cursor_q <= '0;
      fill_q <= '0;
      sel_q <= 1'b0;
    end else begin
      if (cmd_i.ord_adv) ord_q <= ord_q + 64'd1;
      if (cmd_i.load_in) sel_q <= 1'b0;
      else if (cmd_i.sel_load) sel_q <= sel_now;
      if (cmd_i.finish && sel_q) begin
        if (!type_q) begin
          prev_x_q <= va_q;
          prev_y_q <= vb_q;
        end else begin
          cursor_q <= (cursor_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : cursor_q + 1'b1;
          if (fill_q != FILL_W'(HISTORY_DEPTH)) fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      type_q <= req_type_i;
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      lane_q <= lane_id_i;
      cidx_q <= coeff_index_i;
      va_q <= value_a_i;
      vb_q <= value_b_i;
    end
    if (cmd_i.ord_adv) cur_ord_q <= ord_q;
    if (cmd_i.rem_cap_a) rem_a_q <= div_rem[STEP_W-1:0];
    if (cmd_i.rem_cap_b) rem_b_q <= div_rem[STEP_W-1:0];
    if (cmd_i.finish) begin
      res_a_q <= ra;
      res_b_q <= rb;
      res_sel_q <= sel_q;
      res_chg_q <= nchg;
    end
  end

  // history ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && sel_q && type_q) hist_mem[cursor_q] <= va_q;
    if (cmd_i.mem_rd) hist_rd_q <= hist_mem[div_rem[HIST_AW-1:0]];
  end

  assign sts_o = '{
    active:     type_q ? (coef_on && (va_q != 16'sd0)) : mvd_on,
    is_coef:    type_q,
    sel_now:    sel_now,
    mode_quant: (mode == EFF_QUANT),
    mode_trans: (mode == EFF_TRANS),
    mode_fold:  (mode == EFF_FOLD),
    fill_zero:  (fill_q == '0),
    hash_done:  hash_done,
    div_done:   div_done
  };

  assign result_a_o = res_a_q;
  assign result_b_o = res_b_q;
  assign was_selected_o = res_sel_q;
  assign fields_changed_o = res_chg_q;
endmodule

[rtl/video_syntax_glitch_mutator_unit.sv]
// channel  | dir | handshake         | beat
// req_i    | in  | valid/ready       | req_type pos_x pos_y lane_id coeff_index value_a value_b
// rsp_o    | out | valid/ready       | result_a result_b was_selected fields_changed
// apb      | in  | psel/penable      | effect_mode 0x00, amount_frac 0x08, hash_seed 0x10
//
// one beat at a time: an item outside the enabled family skips hashing, a hashed item
// runs two splitmix hashes, and a selected item then adds one remainder for fold, a
// third hash and a remainder for transplant and two remainders for quantize; each hash
// runs on one shared 32x32 multiplier, each remainder in the 4-bit-per-cycle remainder unit
// reset is asynchronous; the history ring needs no clearing pass
// a new request beat is taken while the previous result waits; the next result then
// holds until the output register is free
module video_syntax_glitch_mutator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vsgm_req_if.sink                      req_i,
  vsgm_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vsgm_pkg::PADDR_W-1:0]  paddr,
  input  logic [vsgm_pkg::PDATA_W-1:0]  pwdata,
  output logic [vsgm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import vsgm_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    out_valid;

  vsgm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vsgm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vsgm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .pos_x_i          (req_i.pos_x),
    .pos_y_i          (req_i.pos_y),
    .lane_id_i        (req_i.lane_id),
    .coeff_index_i    (req_i.coeff_index),
    .value_a_i        (req_i.value_a),
    .value_b_i        (req_i.value_b),
    .result_a_o       (rsp_o.result_a),
    .result_b_o       (rsp_o.result_b),
    .was_selected_o   (rsp_o.was_selected),
    .fields_changed_o (rsp_o.fields_changed)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;
endmodule

[rtl/vsgm_chk.sv]
module vsgm_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       was_selected_i,
  input logic [1:0] fields_changed_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result beat dropped while stalled");

  a_unsel_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !was_selected_i |-> fields_changed_i == 2'd0)
    else $error("unselected item reports changes");

  a_chg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> fields_changed_i != 2'd3)
    else $error("change count out of range");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous item in flight");

endmodule

bind video_syntax_glitch_mutator_unit vsgm_chk u_vsgm_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .was_selected_i   (rsp_o.was_selected),
  .fields_changed_i (rsp_o.fields_changed)
);
